// ===== rtl/klm_pkg.sv =====
package klm_pkg;
  localparam int SLOT_CNT_DEF  = 32;
  localparam int KEY_BITS_DEF  = 32;
  localparam int REF_BITS_DEF  = 16;
  localparam int CFG_W   = 6;
  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int SIDX_W  = 5;
  localparam int STAT_W  = 4;
  localparam int QDEPTH  = 2;

  typedef enum logic [1:0] {
    OP_GET = 2'd0, OP_PUT = 2'd1, OP_EVICT = 2'd2, OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_NO_SLOTS  = 4'd0, ST_HIT = 4'd1, ST_PROGRAM = 4'd2, ST_RETRY = 4'd3,
    ST_PUT_DONE  = 4'd4, ST_PUT_IGN = 4'd5, ST_EVICTED = 4'd6,
    ST_EVICT_BSY = 4'd7, ST_EVICT_NF = 4'd8, ST_EVICT_FWD = 4'd9
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key_id;
    logic [SIDX_W-1:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIDX_W-1:0] slot_index_out;
    logic              slot_valid;
  } rsp_t;
endpackage

// ===== rtl/klm_req_if.sv =====
interface klm_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [31:0]       key_id;
  logic [4:0]        slot_index;
  modport source (output valid, opcode, key_id, slot_index, input ready);
  modport sink   (input valid, opcode, key_id, slot_index, output ready);
endinterface

// ===== rtl/klm_rsp_if.sv =====
interface klm_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [4:0]  slot_index_out;
  logic        slot_valid;
  modport source (output valid, status, slot_index_out, slot_valid, input ready);
  modport sink   (input valid, status, slot_index_out, slot_valid, output ready);
endinterface

// ===== rtl/klm_cfg_if.sv =====
interface klm_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/klm_front.sv =====
module klm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            flush,
  input  logic            in_valid,
  output logic            in_ready,
  input  klm_pkg::req_t   in_req,
  output logic            q_valid,
  input  logic            q_ready,
  output klm_pkg::req_t   q_req
);
  // two-entry queue between classification and execution
  klm_pkg::req_t q_mem_r [klm_pkg::QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  klm_pkg::req_t cls;

  always_comb begin
    cls = in_req;
    // unknown opcode is folded into the reserved code
    if (in_req.op != klm_pkg::OP_GET && in_req.op != klm_pkg::OP_PUT &&
        in_req.op != klm_pkg::OP_EVICT) cls.op = klm_pkg::OP_RSVD;
  end

  assign in_ready = (cnt_r != 2'd2) && !flush;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign pop      = q_valid && q_ready;
  assign q_req    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cls;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && !flush) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count did not follow push");
endmodule

// ===== rtl/klm_back.sv =====
module klm_back #(
  parameter int SLOT_CNT  = klm_pkg::SLOT_CNT_DEF,
  parameter int KEY_BITS  = klm_pkg::KEY_BITS_DEF,
  parameter int REF_BITS  = klm_pkg::REF_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     init,
  input  logic [klm_pkg::CFG_W-1:0] init_slots,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  klm_pkg::req_t            q_req,
  output logic                     out_valid,
  input  logic                     out_ready,
  output klm_pkg::rsp_t            out_rsp
);
  localparam int SW = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
  localparam int CW = $clog2(SLOT_CNT + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  logic [KEY_BITS-1:0] key_r   [SLOT_CNT];
  logic                kval_r  [SLOT_CNT];
  logic [REF_BITS-1:0] ref_r   [SLOT_CNT];
  logic [SW-1:0]       nxt_r   [SLOT_CNT];
  logic [SW-1:0]       prv_r   [SLOT_CNT];
  logic [SW-1:0]       head_r, tail_r;
  logic [CW-1:0]       icnt_r, neff_r;
  logic                ov_r;
  klm_pkg::rsp_t       rsp_r;

  logic [CW-1:0] neff_in;
  logic [KEY_BITS-1:0] key;
  logic          hit;
  logic [SW-1:0] hs;
  logic          take;
  logic          do_rm, do_add, do_inc, do_dec, do_prog, do_clr;
  logic [SW-1:0] s, ps, rs, rp, rn;
  logic [SW-1:0] put_s;
  logic          put_ok;
  klm_pkg::rsp_t rsp;

  assign q_ready   = !ov_r || out_ready;
  assign take      = q_valid && q_ready && !init;
  assign out_valid = ov_r;
  assign out_rsp   = rsp_r;
  assign key       = q_req.key_id[KEY_BITS-1:0];
  assign neff_in   = (init_slots > CW'(SLOT_CNT)) ? CW'(SLOT_CNT) : CW'(init_slots);

  // parallel key compare, lowest index wins
  always_comb begin
    hit = 1'b0;
    hs  = '0;
    for (int i = SLOT_CNT - 1; i >= 0; i--) begin
      if (kval_r[i] && key_r[i] == key && CW'(i) < neff_r) begin
        hit = 1'b1;
        hs  = SW'(i);
      end
    end
  end

  assign put_s  = q_req.slot_index[SW-1:0];
  assign put_ok = ({{(8-klm_pkg::SIDX_W){1'b0}}, q_req.slot_index} < 8'(neff_r)) &&
                  (ref_r[put_s] != '0);

  always_comb begin
    rsp     = '{status: klm_pkg::ST_NO_SLOTS, slot_index_out: '0, slot_valid: 1'b0};
    do_rm   = 1'b0; do_add = 1'b0; do_inc = 1'b0; do_dec = 1'b0;
    do_prog = 1'b0; do_clr = 1'b0;
    s       = '0;
    unique case (q_req.op)
      klm_pkg::OP_GET: begin
        if (neff_r == '0) rsp.status = klm_pkg::ST_NO_SLOTS;
        else if (hit) begin
          s = hs;
          if (ref_r[hs] == REF_MAX) rsp.status = klm_pkg::ST_RETRY;
          else begin
            do_inc = 1'b1;
            do_rm  = (ref_r[hs] == '0);
            rsp.status = klm_pkg::ST_HIT;
            rsp.slot_valid = 1'b1;
          end
        end else if (icnt_r == '0) rsp.status = klm_pkg::ST_RETRY;
        else begin
          s = head_r;
          do_rm = 1'b1; do_prog = 1'b1;
          rsp.status = klm_pkg::ST_PROGRAM;
          rsp.slot_valid = 1'b1;
        end
      end
      klm_pkg::OP_PUT: begin
        if (!put_ok) rsp.status = klm_pkg::ST_PUT_IGN;
        else begin
          s = put_s;
          do_dec = 1'b1;
          do_add = (ref_r[put_s] == REF_BITS'(1));
          rsp.status = klm_pkg::ST_PUT_DONE;
          rsp.slot_valid = 1'b1;
        end
      end
      klm_pkg::OP_EVICT: begin
        if (neff_r == '0) rsp.status = klm_pkg::ST_EVICT_FWD;
        else if (!hit) rsp.status = klm_pkg::ST_EVICT_NF;
        else begin
          s = hs;
          rsp.slot_valid = 1'b1;
          if (ref_r[hs] != '0) rsp.status = klm_pkg::ST_EVICT_BSY;
          else begin
            do_clr = 1'b1;
            rsp.status = klm_pkg::ST_EVICTED;
          end
        end
      end
      default: rsp.status = klm_pkg::ST_NO_SLOTS;
    endcase
    rsp.slot_index_out = rsp.slot_valid ? klm_pkg::SIDX_W'(s) : '0;
  end

  assign rp = prv_r[s];
  assign rn = nxt_r[s];
  assign ps = tail_r;
  assign rs = s;

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      for (int i = 0; i < SLOT_CNT; i++) begin
        kval_r[i] <= 1'b0;
        ref_r[i]  <= '0;
        nxt_r[i]  <= (i + 1 < SLOT_CNT) ? SW'(i + 1) : '0;
        prv_r[i]  <= (i > 0) ? SW'(i - 1) : '0;
      end
      head_r <= '0;
      if (!rst_n) begin
        neff_r <= CW'(SLOT_CNT);
        icnt_r <= CW'(SLOT_CNT);
        tail_r <= SW'(SLOT_CNT - 1);
      end else begin
        neff_r <= neff_in;
        icnt_r <= neff_in;
        tail_r <= (neff_in != '0) ? SW'(neff_in - CW'(1)) : '0;
      end
    end else if (take) begin
      if (do_inc) ref_r[s] <= ref_r[s] + REF_BITS'(1);
      if (do_dec) ref_r[s] <= ref_r[s] - REF_BITS'(1);
      if (do_prog) begin
        kval_r[s] <= 1'b1;
        ref_r[s]  <= REF_BITS'(1);
      end
      if (do_clr) kval_r[s] <= 1'b0;
      if (do_rm && icnt_r != '0) begin
        if (rs == head_r) head_r <= rn;
        else nxt_r[rp] <= rn;
        if (rs == tail_r) tail_r <= rp;
        else prv_r[rn] <= rp;
        icnt_r <= icnt_r - CW'(1);
      end
      if (do_add) begin
        if (icnt_r == '0) head_r <= rs;
        else begin
          nxt_r[ps] <= rs;
          prv_r[rs] <= ps;
        end
        tail_r <= rs;
        icnt_r <= icnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && do_prog) key_r[s] <= key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) ov_r <= 1'b0;
    else if (take) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) rsp_r <= rsp;
  end

  a_icnt_le: assert property (@(posedge clk) disable iff (!rst_n) icnt_r <= neff_r)
    else $error("idle count above slot count");
  a_prog_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (take && do_prog) |=> kval_r[$past(s)]) else $error("programmed slot not valid");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && !init) |=> out_valid && $stable(rsp_r))
    else $error("result dropped while stalled");
endmodule

// ===== rtl/keyslot_lru_manager_core.sv =====
// channel   dir   payload                               handshake
// in_       in    opcode, key_id, slot_index            valid/ready
// out_      out   status, slot_index_out, slot_valid     valid/ready
// cfg_      in    data (active_slots)                   valid/ready
// one result per transaction; the back end handles each item as it takes it
// from the queue, so up to one item per cycle while out_ is not stalled; the
// result is registered; all-slot key compare and idle list update act on the take.
// rst_n is synchronous; a cfg_ write reinitialises all slots and flushes the queue.
// either side may stall; a two-entry queue and the output register absorb it.
module keyslot_lru_manager_core #(
  parameter int SLOT_CNT  = klm_pkg::SLOT_CNT_DEF,
  parameter int KEY_BITS  = klm_pkg::KEY_BITS_DEF,
  parameter int REF_BITS  = klm_pkg::REF_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  klm_req_if.sink   in_ch,
  klm_rsp_if.source out_ch,
  klm_cfg_if.sink   cfg_ch
);
  klm_pkg::req_t in_req, q_req;
  klm_pkg::rsp_t rsp;
  logic q_valid, q_ready, init;

  assign cfg_ch.ready = 1'b1;
  assign init = cfg_ch.valid;
  assign in_req = '{op: klm_pkg::op_t'(in_ch.opcode), key_id: in_ch.key_id,
                    slot_index: in_ch.slot_index};

  klm_front u_front (
    .clk, .rst_n, .flush(init),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req,
    .q_valid, .q_ready, .q_req
  );

  klm_back #(.SLOT_CNT(SLOT_CNT), .KEY_BITS(KEY_BITS), .REF_BITS(REF_BITS)) u_back (
    .clk, .rst_n, .init, .init_slots(cfg_ch.data),
    .q_valid, .q_ready, .q_req,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rsp(rsp)
  );

  assign out_ch.status         = rsp.status;
  assign out_ch.slot_index_out = rsp.slot_index_out;
  assign out_ch.slot_valid     = rsp.slot_valid;
endmodule
